>>> src/aac_pkg.sv
// Package: types, constants and opcodes for the allocation access checker.
package aac_pkg;

  localparam int MaxRegions     = 16;
  localparam int MaxRegionBytes = 4096;
  localparam int MaxAccessBytes = 16;
  localparam int AddrBits       = 32;

  localparam int AddrW = 32;
  localparam int LenW  = 13;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY_ALLOC  = 4'd1,
    ST_DOUBLE_ALLOC = 4'd2,
    ST_TABLE_FULL   = 4'd3,
    ST_FREE_UNKNOWN = 4'd4,
    ST_FREE_INTER   = 4'd5,
    ST_FREE_STACK   = 4'd6,
    ST_READ_UNALLOC = 4'd7,
    ST_READ_UNINIT  = 4'd8,
    ST_WRITE_UNALLOC = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
    logic            stack_flag;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status;
    logic             hint_valid;
    logic [AddrW-1:0] hint_start;
    logic [4:0]       live_regions;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLEAR,
    S_BITS,
    S_DONE
  } state_t;

endpackage

>>> src/aac_init_mem.sv
// Init-bit memory: one bit per byte of each region slot, registered read.
module aac_init_mem
  import aac_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/allocation_access_checker_core.sv
// Top level: region table, event sequencer and init-bit memory.
// Each event scans every slot, then on an allocation clears the init words
//   of the slot, and on an access checks (read) or sets (write) each byte's bit.
// One event at a time: in_ready is high only while idle, so the slot scan and
//   the byte-serial read-modify-write of the init memory hold off the next.
// Reset (rst, synchronous): all slots invalid, live count zero, sequencer idle.
// The result register holds a beat until taken; a new event is taken meanwhile.
module allocation_access_checker_core
  import aac_pkg::*;
#(
  parameter int MAX_REGIONS      = MaxRegions,
  parameter int MAX_REGION_BYTES = MaxRegionBytes,
  parameter int MAX_ACCESS_BYTES = MaxAccessBytes,
  parameter int ADDR_BITS        = AddrBits
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int SW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW    = $clog2(MAX_REGIONS + 1);
  localparam int WPR   = (MAX_REGION_BYTES + 63) / 64;
  localparam int WW    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int IDEP  = MAX_REGIONS * WPR;
  localparam int IAW   = (IDEP > 1) ? $clog2(IDEP) : 1;
  localparam int AW    = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam int LW    = $clog2(MAX_REGION_BYTES + 1);
  localparam int KW    = $clog2(MAX_ACCESS_BYTES + 1);
  localparam logic [AW:0] AMAX = {1'b0, {AW{1'b1}}};

  logic [AW-1:0] rs_mem [MAX_REGIONS];
  logic [LW-1:0] rl_mem [MAX_REGIONS];
  logic          rk_mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] rvalid;

  state_t state, state_next;
  logic [1:0]    op;
  logic [AW-1:0] addr;
  logic [LenW-1:0] len;
  logic          flag;
  logic [SW:0]   idx;
  logic          scan_end;
  logic [AW-1:0] rd_s;
  logic [LW-1:0] rd_l;
  logic          rd_k;
  logic          rd_v;
  logic          hv;
  logic [AW-1:0] hs;
  logic [SW-1:0] hslot;
  logic [LW-1:0] hlen;
  logic          hk;
  logic          ovl;
  logic          fv;
  logic [SW-1:0] fslot;
  logic [CW-1:0] live;
  logic [3:0]    st;
  logic [LW-1:0] from;
  logic [KW-1:0] k;
  logic          phase;
  logic [WW:0]   cw;
  logic          ov_full;

  logic          mwe;
  logic [IAW-1:0] mwa, mra;
  logic [63:0]   mwd, mrd;

  aac_init_mem #(.Depth(IDEP), .AW(IAW)) u_mem (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  assign scan_end = (idx == (SW+1)'(MAX_REGIONS));

  // length clipped for allocation
  logic [LW-1:0] alen;
  always_comb begin
    if (32'(len) > 32'(MAX_REGION_BYTES)) begin
      alen = LW'(MAX_REGION_BYTES);
    end else begin
      alen = LW'(len);
    end
  end

  // last byte computations with top-address clamp
  logic [AW:0] new_last_w, rd_last_w, h_last_w, acc_last_w;
  logic [AW-1:0] new_last, rd_last, h_last;
  logic acc_wrap;
  assign new_last_w = {1'b0, addr} + (AW+1)'(alen) - (AW+1)'(1);
  assign new_last   = (new_last_w > AMAX) ? AMAX[AW-1:0] : new_last_w[AW-1:0];
  assign rd_last_w  = {1'b0, rd_s} + (AW+1)'(rd_l) - (AW+1)'(1);
  assign rd_last    = (rd_last_w > AMAX) ? AMAX[AW-1:0] : rd_last_w[AW-1:0];
  assign h_last_w   = {1'b0, hs} + (AW+1)'(hlen) - (AW+1)'(1);
  assign h_last     = (h_last_w > AMAX) ? AMAX[AW-1:0] : h_last_w[AW-1:0];
  assign acc_last_w = {1'b0, addr} + (AW+1)'(len) - (AW+1)'(1);
  assign acc_wrap   = acc_last_w > AMAX;

  logic contained, len_bad;
  assign contained = hv && !acc_wrap && (acc_last_w[AW-1:0] <= h_last);
  assign len_bad   = (len == '0) || (len > LenW'(MAX_ACCESS_BYTES));

  logic [AW-1:0] offs;
  assign offs = addr - hs;

  logic [LW-1:0] boff;
  assign boff = from + LW'(k);
  logic [IAW-1:0] baddr;
  assign baddr = IAW'(hslot) * IAW'(WPR) + IAW'(boff >> 6);

  always_ff @(posedge clk) begin
    if (!scan_end) begin
      rd_s <= rs_mem[idx[SW-1:0]];
      rd_l <= rl_mem[idx[SW-1:0]];
      rd_k <= rk_mem[idx[SW-1:0]];
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    mwe = 1'b0;
    mwa = baddr;
    mwd = mrd | (64'd1 << boff[5:0]);
    mra = baddr;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (scan_end && !rd_v) state_next = S_DECIDE;
      S_DECIDE: begin
        if (op == OP_ALLOC) begin
          if (len == '0 || ovl || !fv) state_next = S_DONE;
          else state_next = S_CLEAR;
        end else if (op == OP_FREE) begin
          state_next = S_DONE;
        end else if (len_bad || !contained) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BITS;
        end
      end
      S_CLEAR: begin
        mwe = 1'b1;
        mwa = IAW'(fslot) * IAW'(WPR) + IAW'(cw);
        mwd = '0;
        if (cw == (WW+1)'(WPR - 1)) state_next = S_DONE;
      end
      S_BITS: begin
        if (phase) begin
          if (op == OP_WRITE) mwe = 1'b1;
          if (op == OP_READ && !mrd[boff[5:0]]) state_next = S_DONE;
          else if (k == KW'(len - 1)) state_next = S_DONE;
        end
      end
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rvalid    <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.operation;
            addr  <= in_data.address[AW-1:0];
            len   <= in_data.length;
            flag  <= in_data.stack_flag;
            idx   <= '0;
            rd_v  <= 1'b0;
            hv    <= 1'b0;
            ovl   <= 1'b0;
            fv    <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_v <= !scan_end;
          if (!scan_end) idx <= idx + 1'b1;
          if (rd_v) begin
            if (rvalid[SW'(idx - 1'b1)]) begin
              if (rd_s <= addr && (!hv || rd_s > hs)) begin
                hv <= 1'b1; hs <= rd_s; hslot <= SW'(idx - 1'b1);
                hlen <= rd_l; hk <= rd_k;
              end
              if (addr <= rd_last && rd_s <= new_last) ovl <= 1'b1;
            end else if (!fv) begin
              fv <= 1'b1; fslot <= SW'(idx - 1'b1);
            end
          end
        end
        S_DECIDE: begin
          from <= LW'(offs);
          k <= '0; phase <= 1'b0; cw <= '0;
          if (op == OP_ALLOC) begin
            if (len == '0) st <= ST_EMPTY_ALLOC;
            else if (ovl) st <= ST_DOUBLE_ALLOC;
            else if (!fv) st <= ST_TABLE_FULL;
            else begin
              st <= ST_OK;
              rs_mem[fslot] <= addr; rl_mem[fslot] <= alen; rk_mem[fslot] <= flag;
              rvalid[fslot] <= 1'b1;
              live <= live + 1'b1;
            end
          end else if (op == OP_FREE) begin
            if (!hv || addr > h_last) st <= ST_FREE_UNKNOWN;
            else if (hs != addr) st <= ST_FREE_INTER;
            else if (hk && !flag) st <= ST_FREE_STACK;
            else begin
              st <= ST_OK;
              rvalid[hslot] <= 1'b0;
              live <= live - 1'b1;
            end
          end else if (len_bad || !contained) begin
            st <= (op == OP_WRITE) ? ST_WRITE_UNALLOC : ST_READ_UNALLOC;
          end else begin
            st <= ST_OK;
          end
        end
        S_CLEAR: cw <= cw + 1'b1;
        S_BITS: begin
          phase <= !phase;
          if (phase) begin
            if (op == OP_READ && !mrd[boff[5:0]]) st <= ST_READ_UNINIT;
            k <= k + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.status       <= st;
            out_data.hint_valid   <= hv;
            out_data.hint_start   <= hv ? AddrW'(hs) : '0;
            out_data.live_regions <= 5'(live);
          end
        end
        default: ;
      endcase
    end
  end

  assign ov_full = live > CW'(MAX_REGIONS);

  assert property (@(posedge clk) disable iff (rst) !ov_full)
    else $error("live count above table size");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (op == OP_ALLOC))
    else $error("clear outside alloc");

endmodule
